### hw/rtl/iocq_pkg.sv
// shared types, codes and sizes for the in-order completion task queue
package iocq_pkg;

    // field widths of one command and one response
    localparam int FUNC_BITS   = 3;
    localparam int ADDR_BITS   = 32;
    localparam int LEN_BITS    = 20;
    localparam int TAG_BITS    = 4;
    localparam int RESULT_BITS = 32;
    localparam int STATUS_BITS = 3;
    localparam int CFG_BITS    = 5;

    // ring depth default and the ring size after reset is capped here
    localparam int SLOTS_DEFAULT  = 16;
    localparam int RING_RESET_MAX = 16;

    // command codes
    localparam logic [FUNC_BITS-1:0] FUNC_PUSH_TASK  = 3'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_PUSH_TERM  = 3'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_CLAIM_TASK = 3'd2;
    localparam logic [FUNC_BITS-1:0] FUNC_POST_RES   = 3'd3;
    localparam logic [FUNC_BITS-1:0] FUNC_CLAIM_RES  = 3'd4;

    // status codes
    localparam logic [STATUS_BITS-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_NO_TASK   = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_NOT_READY = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_BAD_SLOT  = 3'd4;

    // one command transfer
    typedef struct packed {
        logic [FUNC_BITS-1:0]   func;
        logic [ADDR_BITS-1:0]   task_addr;
        logic [LEN_BITS-1:0]    task_len;
        logic [TAG_BITS-1:0]    slot;
        logic [RESULT_BITS-1:0] post_word;
    } cmd_t;

    // one response transfer
    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [TAG_BITS-1:0]    out_slot;
        logic [ADDR_BITS-1:0]   out_task_addr;
        logic [LEN_BITS-1:0]    out_task_len;
        logic                   is_termination;
        logic [RESULT_BITS-1:0] out_result_data;
        logic                   queue_empty;
    } rsp_t;

    // memory strobes from the ring control
    typedef struct packed {
        logic task_we;
        logic task_re;
        logic res_we;
        logic res_re;
    } mem_ctl_t;

    // registered response control, data comes from the memories
    typedef struct packed {
        logic                   done;
        logic [STATUS_BITS-1:0] status;
        logic [TAG_BITS-1:0]    slot;
        logic                   term;
        logic                   sel_task;
        logic                   sel_res;
        logic                   empty;
    } rsp_ctl_t;

endpackage

### hw/rtl/iocq_ram.sv
// simple dual-port memory with one write port and one registered read port
module iocq_ram #(
    parameter int WIDTH = iocq_pkg::RESULT_BITS,
    parameter int DEPTH = iocq_pkg::SLOTS_DEFAULT
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/iocq_ctrl.sv
// ring pointers, occupancy counts, slot marks and per-command decisions
module iocq_ctrl #(
    parameter int SLOTS = iocq_pkg::SLOTS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  iocq_pkg::cmd_t                cmd,
    input  logic                          cfg_we,
    input  logic [iocq_pkg::CFG_BITS-1:0] cfg_wdata,
    output iocq_pkg::mem_ctl_t            mem_ctl,
    output logic [$clog2(SLOTS)-1:0]      task_waddr,
    output logic [$clog2(SLOTS)-1:0]      task_raddr,
    output logic [$clog2(SLOTS)-1:0]      res_waddr,
    output logic [$clog2(SLOTS)-1:0]      res_raddr,
    output iocq_pkg::rsp_ctl_t            rsp_ctl
);

    localparam int PW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int RESET_RING =
        (SLOTS < iocq_pkg::RING_RESET_MAX) ? SLOTS : iocq_pkg::RING_RESET_MAX;

    logic [CW-1:0]    ring_reg, ring_next;
    logic [PW-1:0]    app_reg, app_next;
    logic [PW-1:0]    disp_reg, disp_next;
    logic [PW-1:0]    ret_reg, ret_next;
    logic [CW-1:0]    occ_reg, occ_next;
    logic [CW-1:0]    pend_reg, pend_next;
    logic [SLOTS-1:0] term_reg, term_next;
    logic [SLOTS-1:0] comp_reg, comp_next;
    iocq_pkg::rsp_ctl_t rsp_reg, rsp_next;

    logic [31:0] n32;
    logic [31:0] s32;
    logic [31:0] r32;
    logic [31:0] dist32;
    logic [31:0] claimed32;
    logic [31:0] cfg32;
    logic [PW-1:0] sidx;
    logic [CW-1:0] claimed;

    // next pointer value with wrap at the ring size
    function automatic logic [PW-1:0] advance(input logic [PW-1:0] p, input logic [31:0] n);
        logic [31:0] inc;
        begin
            inc = 32'(p) + 32'd1;
            advance = (inc >= n) ? '0 : inc[PW-1:0];
        end
    endfunction

    // slot tag and pointer to response tag width
    function automatic logic [iocq_pkg::TAG_BITS-1:0] to_tag(input logic [PW-1:0] p);
        logic [31:0] w;
        begin
            w = 32'(p);
            to_tag = w[iocq_pkg::TAG_BITS-1:0];
        end
    endfunction

    assign n32       = 32'(ring_reg);
    assign s32       = 32'(cmd.slot);
    assign r32       = 32'(ret_reg);
    assign sidx      = s32[PW-1:0];
    assign claimed   = occ_reg - pend_reg;
    assign claimed32 = 32'(claimed);
    assign dist32    = (s32 >= r32) ? (s32 - r32) : (s32 + n32 - r32);
    assign cfg32     = 32'(cfg_wdata);

    // memory addresses follow the pointers and the posted tag
    assign task_waddr = app_reg;
    assign task_raddr = disp_reg;
    assign res_waddr  = sidx;
    assign res_raddr  = ret_reg;

    // command decode and state update
    always_comb
    begin
        ring_next = ring_reg;
        app_next  = app_reg;
        disp_next = disp_reg;
        ret_next  = ret_reg;
        occ_next  = occ_reg;
        pend_next = pend_reg;
        term_next = term_reg;
        comp_next = comp_reg;
        mem_ctl   = '0;
        rsp_next  = '0;

        if (cfg_we)
        begin
            // new ring size empties the ring
            if (cfg32 == 32'd0)
            begin
                ring_next = CW'(1);
            end
            else if (cfg32 > 32'(SLOTS))
            begin
                ring_next = CW'(SLOTS);
            end
            else
            begin
                ring_next = cfg32[CW-1:0];
            end
            app_next  = '0;
            disp_next = '0;
            ret_next  = '0;
            occ_next  = '0;
            pend_next = '0;
            term_next = '0;
            comp_next = '0;
        end
        else if (accept)
        begin
            rsp_next.done = 1'b1;
            case (cmd.func)
                iocq_pkg::FUNC_PUSH_TASK, iocq_pkg::FUNC_PUSH_TERM:
                begin
                    if (32'(occ_reg) >= n32)
                    begin
                        rsp_next.status = iocq_pkg::ST_FULL;
                    end
                    else
                    begin
                        mem_ctl.task_we = (cmd.func == iocq_pkg::FUNC_PUSH_TASK);
                        term_next[app_reg] = (cmd.func == iocq_pkg::FUNC_PUSH_TERM);
                        comp_next[app_reg] = (cmd.func == iocq_pkg::FUNC_PUSH_TERM);
                        app_next  = advance(app_reg, n32);
                        occ_next  = occ_reg + CW'(1);
                        pend_next = pend_reg + CW'(1);
                        rsp_next.slot = to_tag(app_reg);
                    end
                end
                iocq_pkg::FUNC_CLAIM_TASK:
                begin
                    if (pend_reg == '0)
                    begin
                        rsp_next.status = iocq_pkg::ST_NO_TASK;
                    end
                    else
                    begin
                        mem_ctl.task_re   = 1'b1;
                        rsp_next.slot     = to_tag(disp_reg);
                        rsp_next.term     = term_reg[disp_reg];
                        rsp_next.sel_task = !term_reg[disp_reg];
                        disp_next = advance(disp_reg, n32);
                        pend_next = pend_reg - CW'(1);
                    end
                end
                iocq_pkg::FUNC_POST_RES:
                begin
                    if (s32 >= n32)
                    begin
                        rsp_next.status = iocq_pkg::ST_BAD_SLOT;
                    end
                    else if (dist32 >= claimed32 || term_reg[sidx])
                    begin
                        rsp_next.status = iocq_pkg::ST_BAD_SLOT;
                    end
                    else
                    begin
                        mem_ctl.res_we  = 1'b1;
                        comp_next[sidx] = 1'b1;
                        rsp_next.slot   = cmd.slot;
                    end
                end
                iocq_pkg::FUNC_CLAIM_RES:
                begin
                    if (claimed == '0 || !comp_reg[ret_reg])
                    begin
                        rsp_next.status = iocq_pkg::ST_NOT_READY;
                    end
                    else
                    begin
                        mem_ctl.res_re   = 1'b1;
                        rsp_next.slot    = to_tag(ret_reg);
                        rsp_next.term    = term_reg[ret_reg];
                        rsp_next.sel_res = !term_reg[ret_reg];
                        term_next[ret_reg] = 1'b0;
                        comp_next[ret_reg] = 1'b0;
                        ret_next = advance(ret_reg, n32);
                        occ_next = occ_reg - CW'(1);
                    end
                end
                default:
                begin
                    rsp_next.status = iocq_pkg::ST_BAD_SLOT;
                end
            endcase
            rsp_next.empty = (occ_next == '0);
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_reg <= CW'(RESET_RING);
            app_reg  <= '0;
            disp_reg <= '0;
            ret_reg  <= '0;
            occ_reg  <= '0;
            pend_reg <= '0;
            term_reg <= '0;
            comp_reg <= '0;
            rsp_reg  <= '0;
        end
        else
        begin
            ring_reg <= ring_next;
            app_reg  <= app_next;
            disp_reg <= disp_next;
            ret_reg  <= ret_next;
            occ_reg  <= occ_next;
            pend_reg <= pend_next;
            term_reg <= term_next;
            comp_reg <= comp_next;
            rsp_reg  <= rsp_next;
        end
    end

    assign rsp_ctl = rsp_reg;

endmodule

### hw/rtl/in_order_completion_task_queue.sv
// in-order completion task queue: one response per command, except when a ring size write takes its cycle
// the response strobe (done) is registered and comes in the cycle after a command transfer
// throughput: one command per cycle; busy stays low, the receiver cannot stall
// each command passes the control logic once and uses at most one task or result memory port
// reset: pointers, counts and slot marks clear at once, ring size returns to SLOTS capped at 16
// task and result memories are not cleared; a ring size write empties the ring
module in_order_completion_task_queue #(
    parameter int SLOTS = iocq_pkg::SLOTS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  iocq_pkg::cmd_t                cmd,
    output logic                          busy,
    output logic                          done,
    output iocq_pkg::rsp_t                rsp,
    input  logic                          cfg_we,
    input  logic [iocq_pkg::CFG_BITS-1:0] cfg_wdata
);

    localparam int PW = $clog2(SLOTS);
    localparam int TW = iocq_pkg::ADDR_BITS + iocq_pkg::LEN_BITS;

    iocq_pkg::mem_ctl_t mem_ctl;
    iocq_pkg::rsp_ctl_t rsp_ctl;
    logic [PW-1:0]      task_waddr;
    logic [PW-1:0]      task_raddr;
    logic [PW-1:0]      res_waddr;
    logic [PW-1:0]      res_raddr;
    logic [TW-1:0]      task_rdata;
    logic [iocq_pkg::RESULT_BITS-1:0] res_rdata;
    logic               accept;

    // commands are taken every cycle
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // ring control
    iocq_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .cmd        (cmd),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .mem_ctl    (mem_ctl),
        .task_waddr (task_waddr),
        .task_raddr (task_raddr),
        .res_waddr  (res_waddr),
        .res_raddr  (res_raddr),
        .rsp_ctl    (rsp_ctl)
    );

    // task address and length store
    iocq_ram #(
        .WIDTH (TW),
        .DEPTH (SLOTS)
    ) u_task_ram (
        .clk   (clk),
        .we    (mem_ctl.task_we),
        .waddr (task_waddr),
        .wdata ({cmd.task_addr, cmd.task_len}),
        .re    (mem_ctl.task_re),
        .raddr (task_raddr),
        .rdata (task_rdata)
    );

    // result word store
    iocq_ram #(
        .WIDTH (iocq_pkg::RESULT_BITS),
        .DEPTH (SLOTS)
    ) u_res_ram (
        .clk   (clk),
        .we    (mem_ctl.res_we),
        .waddr (res_waddr),
        .wdata (cmd.post_word),
        .re    (mem_ctl.res_re),
        .raddr (res_raddr),
        .rdata (res_rdata)
    );

    // response assembly, data fields zero unless selected
    always_comb
    begin
        done                = rsp_ctl.done;
        rsp.status          = rsp_ctl.status;
        rsp.out_slot        = rsp_ctl.slot;
        rsp.is_termination  = rsp_ctl.term;
        rsp.queue_empty     = rsp_ctl.empty;
        rsp.out_task_addr   = rsp_ctl.sel_task ? task_rdata[TW-1:iocq_pkg::LEN_BITS] : '0;
        rsp.out_task_len    = rsp_ctl.sel_task ? task_rdata[iocq_pkg::LEN_BITS-1:0] : '0;
        rsp.out_result_data = rsp_ctl.sel_res ? res_rdata : '0;
    end

endmodule
